// ===== hdl/rfsd_pkg.sv =====
// Shared constants and controller/datapath interface types for the range filter and sorter.
package rfsd_pkg;

   localparam int VAL_W        = 19;
   localparam int CAPACITY_DEF = 64;
   localparam int CSR_ADDR_W   = 1;

   localparam logic signed [VAL_W-1:0] LOW_LIMIT_RESET  = -19'sd256000;
   localparam logic signed [VAL_W-1:0] HIGH_LIMIT_RESET = 19'sd256000;

   localparam logic [CSR_ADDR_W-1:0] REG_LOW_LIMIT  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_HIGH_LIMIT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic insert;
      logic drop;
      logic shift;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_range;
      logic full;
      logic empty;
      logic last_one;
   } status_type;

endpackage

// ===== hdl/range_filter_sort_descending.sv =====
// Top level of the range filter with descending sort.
// Load: one sample transfer per cycle; each kept sample enters a sorted chain.
// The first result is valid the cycle after the set_end transfer; N kept samples
// give one result per cycle while rsp_ready is high (one if empty), req_ready low.
// Reset clears the phase, kept count, drop flag and restores the limit registers.
module range_filter_sort_descending #(
   parameter int CAPACITY = rfsd_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rfsd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic signed [rfsd_pkg::VAL_W-1:0] csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rfsd_pkg::VAL_W-1:0] req_sample,
   input  logic                              req_set_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [rfsd_pkg::VAL_W-1:0] rsp_sorted_value,
   output logic                              rsp_final_res,
   output logic                              rsp_empty_res,
   output logic                              rsp_overflow
);

   rfsd_pkg::cmd_type    cmd;
   rfsd_pkg::status_type status;

   rfsd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_set_end (req_set_end),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .cmd         (cmd)
   );

   rfsd_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_sample       (req_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ===== hdl/rfsd_ctrl.sv =====
// Controller: load and emit phases, handshakes and datapath commands.
module rfsd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_set_end,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rfsd_pkg::status_type status,
   output rfsd_pkg::cmd_type    cmd
);

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;
   logic req_xfer;
   logic rsp_xfer;
   logic set_done;

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid && rsp_ready;

   // The final result of a set is the one taken when at most one entry remains.
   assign set_done = rsp_xfer && (status.empty || status.last_one);

   always_comb begin
      cmd.insert = req_xfer && status.in_range && !status.full;
      cmd.drop   = req_xfer && status.in_range && status.full;
      cmd.shift  = rsp_xfer;
      cmd.clear  = set_done;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer && req_set_end) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (set_done) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/rfsd_datapath.sv =====
// Datapath: limit registers, range compare, sorted insertion chain and result fields.
module rfsd_datapath #(
   parameter int CAPACITY = rfsd_pkg::CAPACITY_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [rfsd_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic signed [rfsd_pkg::VAL_W-1:0]       csr_wdata,
   input  logic signed [rfsd_pkg::VAL_W-1:0]       req_sample,
   input  rfsd_pkg::cmd_type                       cmd,
   output rfsd_pkg::status_type                    status,
   output logic signed [rfsd_pkg::VAL_W-1:0]       rsp_sorted_value,
   output logic                                    rsp_final_res,
   output logic                                    rsp_empty_res,
   output logic                                    rsp_overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [rfsd_pkg::VAL_W-1:0] low_ff;
   logic signed [rfsd_pkg::VAL_W-1:0] high_ff;
   logic signed [rfsd_pkg::VAL_W-1:0] cell_ff [CAPACITY];
   logic signed [rfsd_pkg::VAL_W-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0]               below;
   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  count_in;
   logic                              dropped_ff;
   logic                              dropped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= rfsd_pkg::LOW_LIMIT_RESET;
         high_ff <= rfsd_pkg::HIGH_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            rfsd_pkg::REG_LOW_LIMIT:  low_ff  <= csr_wdata;
            rfsd_pkg::REG_HIGH_LIMIT: high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The chain is kept in descending order. below[i] is high where the new sample
   // belongs ahead of cell i: the cell is unoccupied or holds a smaller value.
   // Equal values keep arrival order, which cannot be seen at the output.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign below[i] = (count_ff <= CNT_W'(i)) || (req_sample > cell_ff[i]);

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (cmd.insert) begin
            if (i > 0 && below[(i > 0) ? i - 1 : 0]) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end else if (below[i]) begin
               cell_in[i] = req_sample;
            end
         end else if (cmd.shift) begin
            if (i < CAPACITY - 1) begin
               cell_in[i] = cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      priority if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.drop) begin
         dropped_in = 1'b1;
      end else if (cmd.shift) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_comb begin
      status.in_range = (req_sample >= low_ff) && (req_sample <= high_ff);
      status.full     = (count_ff == CNT_W'(CAPACITY));
      status.empty    = (count_ff == '0);
      status.last_one = (count_ff == CNT_W'(1));
   end

   assign rsp_sorted_value = status.empty ? '0 : cell_ff[0];
   assign rsp_final_res    = status.empty || status.last_one;
   assign rsp_empty_res    = status.empty;
   assign rsp_overflow     = dropped_ff;

endmodule

// ===== hdl/rfsd_checker.sv =====
// Port-level checker for the range filter with descending sort, bound to the top level.
module rfsd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [rfsd_pkg::VAL_W-1:0] rsp_sorted_value,
   input logic                              rsp_final_res,
   input logic                              rsp_empty_res,
   input logic                              rsp_overflow
);

   // Loading and emitting never overlap.
   a_phase_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input and result channels open at once");

   // An empty set gives a single final result with value zero.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_final_res && (rsp_sorted_value == '0))
      else $error("malformed empty result");

   // Results within a set never increase.
   a_descending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_res |=>
         rsp_valid && ($signed(rsp_sorted_value) <= $signed($past(rsp_sorted_value))))
      else $error("results not in descending order");

   // The overflow flag is the same on every result of a set.
   a_overflow_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_res |=> rsp_overflow == $past(rsp_overflow))
      else $error("overflow flag changed within a set");

   // After the final transfer the block returns to loading.
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_final_res |=> !rsp_valid && req_ready)
      else $error("block did not return to loading after final result");

endmodule

bind range_filter_sort_descending rfsd_checker u_rfsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_final_res    (rsp_final_res),
   .rsp_empty_res    (rsp_empty_res),
   .rsp_overflow     (rsp_overflow)
);

// ===== sim/sort_result_checker.sv =====
// Checker that predicts the sorted results of the range filter and compares each result transfer.
module sort_result_checker #(
   parameter int CAPACITY = rfsd_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rfsd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic signed [rfsd_pkg::VAL_W-1:0] csr_wdata,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [rfsd_pkg::VAL_W-1:0] req_sample,
   input  logic                              req_set_end,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [rfsd_pkg::VAL_W-1:0] rsp_sorted_value,
   input  logic                              rsp_final_res,
   input  logic                              rsp_empty_res,
   input  logic                              rsp_overflow,
   output int                                pending_results,
   output int                                failures,
   output int                                results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [rfsd_pkg::VAL_W-1:0] sample_type;

   typedef struct packed {
      sample_type sorted_value;
      logic       final_res;
      logic       empty_res;
      logic       overflow;
   } result_type;

   sample_type low_limit;
   sample_type high_limit;
   sample_type kept_desc[$];
   logic       dropped;
   result_type due_results[$];

   // Kept samples are held in descending order as they arrive, like the insertion chain.
   task automatic filter_sample(input sample_type value, input logic closes_set);
      int         pos;
      result_type res;
      if (value >= low_limit && value <= high_limit) begin
         if (kept_desc.size() < CAPACITY) begin
            pos = 0;
            while (pos < kept_desc.size() && kept_desc[pos] >= value) pos++;
            kept_desc.insert(pos, value);
         end else begin
            dropped = 1'b1;
         end
      end
      if (closes_set) begin
         if (kept_desc.size() == 0) begin
            res.sorted_value = '0;
            res.final_res    = 1'b1;
            res.empty_res    = 1'b1;
            res.overflow     = dropped;
            due_results.push_back(res);
         end else begin
            foreach (kept_desc[i]) begin
               res.sorted_value = kept_desc[i];
               res.final_res    = (i == kept_desc.size() - 1);
               res.empty_res    = 1'b0;
               res.overflow     = dropped;
               due_results.push_back(res);
            end
         end
         kept_desc.delete();
         dropped = 1'b0;
      end
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   task automatic compare_result();
      result_type want;
      results_seen++;
      if (due_results.size() == 0) begin
         $error("result transfer with nothing due: sorted_value %0d final_res %0b",
                rsp_sorted_value, rsp_final_res);
         failures++;
      end else begin
         want = due_results.pop_front();
         check_field("sorted_value", int'(want.sorted_value), int'(rsp_sorted_value));
         check_field("final_res", int'(want.final_res), int'(rsp_final_res));
         check_field("empty_res", int'(want.empty_res), int'(rsp_empty_res));
         check_field("overflow", int'(want.overflow), int'(rsp_overflow));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         low_limit  = rfsd_pkg::LOW_LIMIT_RESET;
         high_limit = rfsd_pkg::HIGH_LIMIT_RESET;
         dropped    = 1'b0;
         kept_desc.delete();
         due_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               rfsd_pkg::REG_LOW_LIMIT:  low_limit = csr_wdata;
               rfsd_pkg::REG_HIGH_LIMIT: high_limit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) filter_sample(req_sample, req_set_end);
         if (rsp_valid && rsp_ready) compare_result();
      end
      pending_results <= due_results.size();
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the range filter with descending sort.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;

   typedef logic signed [rfsd_pkg::VAL_W-1:0] sample_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [rfsd_pkg::CSR_ADDR_W-1:0] csr_addr = rfsd_pkg::REG_LOW_LIMIT;
   sample_type                      csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   sample_type                      req_sample = '0;
   logic                            req_set_end = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   sample_type                      rsp_sorted_value;
   logic                            rsp_final_res;
   logic                            rsp_empty_res;
   logic                            rsp_overflow;

   int         pending_results;
   int         failures;
   int         results_seen;
   int         send_idle_pct = 25;
   int         recv_idle_pct = 88;
   int         low_now = -256000;
   int         high_now = 256000;
   sample_type last_sample = '0;
   int         samples_sent = 0;
   int         sets_sent = 0;
   int         stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   range_filter_sort_descending DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_set_end      (req_set_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflow     (rsp_overflow)
   );

   sort_result_checker results_check (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_set_end      (req_set_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_empty_res    (rsp_empty_res),
      .rsp_overflow     (rsp_overflow),
      .pending_results  (pending_results),
      .failures         (failures),
      .results_seen     (results_seen)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("range_filter_sort_descending regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // In-range values (mostly, if dense), limits and their neighbors, repeats and raw noise.
   function automatic sample_type pick_sample(input bit dense);
      int roll;
      roll = $urandom_range(99);
      if (low_now <= high_now && roll < (dense ? 95 : 40))
         return sample_type'(low_now + int'($urandom_range(high_now - low_now)));
      if (roll >= 80) return sample_type'($urandom);
      if (roll >= 70) return last_sample;
      case ($urandom_range(3))
         0:       return sample_type'(low_now);
         1:       return sample_type'(high_now);
         2:       return sample_type'(low_now - 1);
         default: return sample_type'(high_now + 1);
      endcase
   endfunction

   task automatic send_sample(input int value, input logic closes_set);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_sample  <= sample_type'(value);
      req_set_end <= closes_set;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
      last_sample = sample_type'(value);
   endtask

   task automatic send_set(input int len, input bit dense);
      for (int i = 0; i < len; i++) send_sample(int'(pick_sample(dense)), i == len - 1);
      sets_sent++;
   endtask

   // Waits until every predicted result has been taken and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limits(input int lo, input int hi);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= rfsd_pkg::REG_LOW_LIMIT;
      csr_wdata <= sample_type'(lo);
      @(posedge clock);
      csr_addr  <= rfsd_pkg::REG_HIGH_LIMIT;
      csr_wdata <= sample_type'(hi);
      @(posedge clock);
      csr_we    <= 1'b0;
      low_now  = lo;
      high_now = hi;
   endtask

   initial begin
      int lo;
      int hi;
      int start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset limits: both extremes kept, raw 19-bit extremes and near misses dropped.
      send_sample(256000, 1'b0);
      send_sample(-256000, 1'b0);
      send_sample(262143, 1'b0);
      send_sample(-262144, 1'b0);
      send_sample(0, 1'b0);
      send_sample(256001, 1'b0);
      send_sample(-256001, 1'b0);
      send_sample(1, 1'b0);
      send_sample(1, 1'b0);
      send_sample(-1, 1'b1);
      send_sample(100, 1'b1);
      send_sample(262143, 1'b1);
      send_sample(-256000, 1'b0);
      send_sample(-256000, 1'b1);
      sets_sent += 4;

      set_limits(-1000, 1000);
      send_sample(1000, 1'b0);
      send_sample(-1000, 1'b0);
      send_sample(1001, 1'b0);
      send_sample(-1001, 1'b0);
      send_sample(999, 1'b1);

      // A low limit above the high limit passes nothing.
      set_limits(10, -10);
      send_sample(0, 1'b0);
      send_sample(5, 1'b1);
      sets_sent += 2;

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       begin send_idle_pct = 25; recv_idle_pct <= 88; end
            1:       begin send_idle_pct = 88; recv_idle_pct <= 25; end
            default: begin send_idle_pct = 0;  recv_idle_pct <= 0;  end
         endcase
         for (int pick = 0; pick < 2; pick++) begin
            case (mode * 2 + pick)
               0:       begin lo = -262144; hi = 262143; end
               1:       begin lo = -1000;   hi = 1000;   end
               2:       begin lo = 5000;    hi = 4999;   end
               3: begin
                  lo = int'($urandom_range(20000)) - 10000;
                  hi = lo + int'($urandom_range(20000));
               end
               4:       begin lo = 300;     hi = 300;    end
               default: begin lo = -256000; hi = 256000; end
            endcase
            set_limits(lo, hi);
            start = samples_sent;
            // One long dense set per mode may run the store to and past capacity.
            if (pick == 0) send_set($urandom_range(62, 74), 1'b1);
            while (samples_sent - start < 65) begin
               if ($urandom_range(99) < 4) send_set($urandom_range(62, 74), 1'b0);
               else send_set($urandom_range(1, 12), 1'b0);
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Run covered %0d samples in %0d sets and checked %0d sorted results.",
               samples_sent, sets_sent, results_seen);
      $display("Limits took nine settings, full span and inverted among them, in three idling modes.");
      if (failures == 0 && pending_results == 0) begin
         $display("range_filter_sort_descending regression: pass");
      end else begin
         $display("range_filter_sort_descending regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rfsd_pkg.sv
hdl/rfsd_ctrl.sv
hdl/rfsd_datapath.sv
hdl/range_filter_sort_descending.sv
hdl/rfsd_checker.sv
sim/sort_result_checker.sv
sim/tb.sv
